// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 32;
  localparam int SUM_W    = 48;
  localparam int QUANT_W  = 8;

  localparam int IN_DATA_W = 24;
  localparam int IN_USER_W = 1;

  // running_valid .. total_wait, before queue_count
  localparam int OUT_FIX_W = 100;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic REG_QUANTUM = 1'b0;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;

  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } entry_t;

endpackage

// File: rtl/round_robin_time_slice_scheduler_unit.sv
`timescale 1ns / 1ps

// Round-robin time-slice scheduler over a ring of QUEUE_DEPTH tasks held in a
// queue memory. Each input transfer is an add (tuser = 0) or a tick (tuser = 1)
// and yields exactly one result transfer. An item is first handled in ST_IDLE,
// which decides from the cached head entry and writes the queue memory (enqueue
// or rotate to tail); ST_WORK then takes the registered read of the next head
// from that memory and loads the result register. Input is taken again once the
// result is in the output register, so a waiting result stalls at most one
// item. The quantum register sits at APB byte address 0; writes take effect
// for the next item and must be made while the block is idle.

module round_robin_time_slice_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((rrts_pkg::OUT_FIX_W + CNT_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // task_id[7:0], burst[23:8]
  input  logic [rrts_pkg::IN_DATA_W-1:0]   s_tdata,
  // action[0]
  input  logic [rrts_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // running_valid[0], running_task[8:1], finished_valid[9], finished_task[17:10],
  // finished_wait[49:18], slice_expired[50], add_dropped[51], total_wait[99:52],
  // queue_count[100 +: CNT_W], zero fill above
  output logic [OUT_W-1:0]                 m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrts_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rrts_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rrts_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import rrts_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic               state;
  logic [QUANT_W-1:0] quantum;
  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   tail_ptr;
  logic [CNT_W-1:0]   occupancy;
  logic [QUANT_W-1:0] slice_left;
  logic [TIME_W-1:0]  time_now;
  logic [SUM_W-1:0]   wait_sum;
  entry_t             head;
  logic               load_pend;
  logic               fin_valid;
  logic [ID_W-1:0]    fin_task;
  logic [TIME_W-1:0]  fin_wait;
  logic               expired;
  logic               dropped;

  logic               accept;
  logic               act;
  entry_t             new_entry;
  logic [PTR_W-1:0]   head_ptr_next;
  logic [PTR_W-1:0]   tail_ptr_next;
  logic               occ_zero;
  logic               occ_full;
  logic               do_finish;
  logic               do_rotate;
  logic [TIME_W-1:0]  wait_calc;
  logic [QUANT_W-1:0] quantum_dec;
  logic               out_free;
  logic               mem_wr_en;
  entry_t             mem_wr_data;
  entry_t             mem_rd_data;
  entry_t             loaded;
  logic               run_valid;
  logic [ID_W-1:0]    run_task;
  logic               cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_QUANTUM);
  assign prdata   = (paddr[2] == REG_QUANTUM) ? APB_DATA_W'(quantum) : '0;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign act      = s_tuser[0];
  assign out_free = !m_tvalid || m_tready;

  assign new_entry.task_id   = s_tdata[ID_W-1:0];
  assign new_entry.remaining = s_tdata[ID_W +: BURST_W];
  assign new_entry.arrival   = time_now;
  assign new_entry.burst     = s_tdata[ID_W +: BURST_W];

  assign head_ptr_next = (head_ptr == LAST_SLOT) ? '0 : head_ptr + PTR_W'(1);
  assign tail_ptr_next = (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + PTR_W'(1);
  assign occ_zero      = (occupancy == '0);
  assign occ_full      = (occupancy == FULL_CNT);
  assign do_finish     = (act == ACT_TICK) && !occ_zero && (head.remaining == '0);
  assign do_rotate     = (act == ACT_TICK) && !occ_zero && (head.remaining != '0) &&
                         (slice_left == '0);
  assign wait_calc     = time_now - head.arrival - TIME_W'(head.burst);
  assign quantum_dec   = (quantum == '0) ? '0 : quantum - QUANT_W'(1);

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_data = new_entry;
    if (accept && !occ_zero && act == ACT_TICK && head.remaining != '0 &&
        slice_left == '0) begin
      mem_wr_en   = 1'b1;
      mem_wr_data = head;
    end else if (accept && act == ACT_ADD && !occ_full) begin
      mem_wr_en   = 1'b1;
    end
  end

  always_comb begin
    loaded = mem_rd_data;
    if (mem_rd_data.remaining != '0) begin
      loaded.remaining = mem_rd_data.remaining - BURST_W'(1);
    end
  end

  assign run_valid = !occ_zero;
  assign run_task  = !run_valid ? '0 : (load_pend ? mem_rd_data.task_id : head.task_id);

  rrts_queue_mem #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W)
  ) u_queue_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail_ptr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (head_ptr_next),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_wr) begin
      quantum <= pwdata[QUANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      occupancy  <= '0;
      slice_left <= QUANTUM_RESET;
      time_now   <= '0;
      wait_sum   <= '0;
      load_pend  <= 1'b0;
      fin_valid  <= 1'b0;
      expired    <= 1'b0;
      dropped    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == ST_WORK && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_WORK;
            fin_valid <= do_finish;
            expired   <= do_rotate;
            dropped   <= (act == ACT_ADD) && occ_full;
            load_pend <= (do_finish || do_rotate) && (occupancy != ONE_CNT);
            if (act == ACT_ADD) begin
              if (!occ_full) begin
                tail_ptr  <= tail_ptr_next;
                occupancy <= occupancy + ONE_CNT;
                if (occ_zero) begin
                  slice_left <= quantum;
                end
              end
            end else begin
              time_now <= time_now + TIME_W'(1);
              if (do_finish) begin
                wait_sum  <= wait_sum + SUM_W'(wait_calc);
                head_ptr  <= head_ptr_next;
                occupancy <= occupancy - ONE_CNT;
                if (occupancy != ONE_CNT) begin
                  slice_left <= quantum_dec;
                end
              end else if (do_rotate) begin
                tail_ptr   <= tail_ptr_next;
                head_ptr   <= head_ptr_next;
                slice_left <= quantum_dec;
              end else if (!occ_zero) begin
                slice_left <= slice_left - QUANT_W'(1);
              end
            end
          end
        end
        ST_WORK: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin_task <= do_finish ? head.task_id : '0;
      fin_wait <= do_finish ? wait_calc : '0;
      if (act == ACT_ADD) begin
        if (!occ_full && occ_zero) begin
          head <= new_entry;
        end
      end else if (!occ_zero && !do_finish) begin
        if (!do_rotate || occupancy == ONE_CNT) begin
          head.remaining <= head.remaining - BURST_W'(1);
        end
      end
    end
    if (state == ST_WORK && out_free) begin
      if (load_pend) begin
        head <= loaded;
      end
      m_tdata <= OUT_W'({occupancy, wait_sum, dropped, expired, fin_wait, fin_task,
                         fin_valid, run_task, run_valid});
    end
  end

endmodule

// File: rtl/rrts_queue_mem.sv
`timescale 1ns / 1ps

module rrts_queue_mem #(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [PTR_W-1:0]   wr_addr,
  input  rrts_pkg::entry_t   wr_data,
  input  logic               rd_en,
  input  logic [PTR_W-1:0]   rd_addr,
  output rrts_pkg::entry_t   rd_data
);
  import rrts_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rrts_checker.sv
`timescale 1ns / 1ps

module rrts_checker #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((rrts_pkg::OUT_FIX_W + CNT_W + 7) / 8) * 8
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [OUT_W-1:0]                 m_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready
);
  import rrts_pkg::*;

  logic [CNT_W-1:0] count;
  logic             run_valid;
  logic             fin_valid;
  logic             expired;
  logic             dropped;

  assign count     = m_tdata[OUT_FIX_W +: CNT_W];
  assign run_valid = m_tdata[0];
  assign fin_valid = m_tdata[9];
  assign expired   = m_tdata[50];
  assign dropped   = m_tdata[51];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue_count above depth");

  a_running_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (run_valid == (count != '0)))
    else $error("running_valid disagrees with queue_count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(fin_valid && expired) && !(dropped && (fin_valid || expired)))
    else $error("conflicting result flags");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind round_robin_time_slice_scheduler_unit rrts_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rrts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// File: test/sched_checker.sv
`timescale 1ns / 1ps

module sched_checker #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((rrts_pkg::OUT_FIX_W + CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // task_id[7:0], burst[23:8]
  input  logic [rrts_pkg::IN_DATA_W-1:0]  s_tdata,
  // action[0]
  input  logic [rrts_pkg::IN_USER_W-1:0]  s_tuser,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // running_valid, running_task, finished_valid, finished_task, finished_wait,
  // slice_expired, add_dropped, total_wait, queue_count, zero fill
  input  logic [OUT_W-1:0]                m_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [rrts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rrts_pkg::APB_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              outstanding
);
  import rrts_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]  queue_count;
    logic [SUM_W-1:0]  total_wait;
    logic              add_dropped;
    logic              slice_expired;
    logic [TIME_W-1:0] finished_wait;
    logic [ID_W-1:0]   finished_task;
    logic              finished_valid;
    logic [ID_W-1:0]   running_task;
    logic              running_valid;
  } sched_result_t;

  localparam int RES_W = $bits(sched_result_t);

  entry_t             ring [QUEUE_DEPTH];
  int                 head_slot;
  int                 tail_slot;
  int                 queued;
  logic [QUANT_W-1:0] slice_left;
  logic [QUANT_W-1:0] quantum_q;
  logic [TIME_W-1:0]  clock_now;
  logic [SUM_W-1:0]   wait_total;
  sched_result_t      pending_results [$];
  int                 fail_total;
  int                 result_index;

  assign mismatches = fail_total;

  function automatic int next_slot(input int slot);
    return (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
  endfunction

  task automatic schedule_item(input logic action, input logic [ID_W-1:0] id,
                               input logic [BURST_W-1:0] need,
                               output sched_result_t res);
    entry_t            cur;
    logic [TIME_W-1:0] waited;
    res = '0;
    if (action == ACT_ADD) begin
      if (queued >= QUEUE_DEPTH) begin
        res.add_dropped = 1'b1;
      end else begin
        ring[tail_slot] = '{task_id: id, remaining: need, arrival: clock_now, burst: need};
        tail_slot = next_slot(tail_slot);
        if (queued == 0) slice_left = quantum_q;
        queued++;
      end
    end else begin
      if (queued != 0) begin
        cur = ring[head_slot];
        if (cur.remaining == '0) begin
          waited = clock_now - cur.arrival - TIME_W'(cur.burst);
          res.finished_valid = 1'b1;
          res.finished_task = cur.task_id;
          res.finished_wait = waited;
          wait_total = wait_total + SUM_W'(waited);
          head_slot = next_slot(head_slot);
          queued--;
          if (queued != 0) slice_left = quantum_q;
        end else if (slice_left == '0) begin
          ring[tail_slot] = cur;
          tail_slot = next_slot(tail_slot);
          head_slot = next_slot(head_slot);
          slice_left = quantum_q;
          res.slice_expired = 1'b1;
        end
        if (queued != 0) begin
          if (ring[head_slot].remaining != '0)
            ring[head_slot].remaining = ring[head_slot].remaining - 1'b1;
          if (slice_left != '0) slice_left = slice_left - 1'b1;
        end
      end
      clock_now = clock_now + 1'b1;
    end
    res.running_valid = (queued != 0);
    res.running_task = (queued != 0) ? ring[head_slot].task_id : '0;
    res.total_wait = wait_total;
    res.queue_count = CNT_W'(queued);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      fail_total++;
      if (fail_total <= 10)
        $display("result %0d: %s expected %0h, got %0h", result_index, name, want, got);
    end
  endtask

  task automatic check_result();
    sched_result_t want;
    sched_result_t got;
    got = sched_result_t'(m_tdata[RES_W-1:0]);
    if (pending_results.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("result %0d: unexpected transfer %0h", result_index, m_tdata);
    end else begin
      want = pending_results.pop_front();
      compare_field("running_valid", 64'(want.running_valid), 64'(got.running_valid));
      compare_field("running_task", 64'(want.running_task), 64'(got.running_task));
      compare_field("finished_valid", 64'(want.finished_valid), 64'(got.finished_valid));
      compare_field("finished_task", 64'(want.finished_task), 64'(got.finished_task));
      compare_field("finished_wait", 64'(want.finished_wait), 64'(got.finished_wait));
      compare_field("slice_expired", 64'(want.slice_expired), 64'(got.slice_expired));
      compare_field("add_dropped", 64'(want.add_dropped), 64'(got.add_dropped));
      compare_field("total_wait", 64'(want.total_wait), 64'(got.total_wait));
      compare_field("queue_count", 64'(want.queue_count), 64'(got.queue_count));
      compare_field("zero fill", '0, 64'(m_tdata >> RES_W));
    end
    result_index++;
  endtask

  initial begin
    fail_total = 0;
    result_index = 0;
  end

  always @(posedge clk) begin
    sched_result_t res;
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) ring[i] = '0;
      head_slot = 0;
      tail_slot = 0;
      queued = 0;
      quantum_q = QUANTUM_RESET;
      slice_left = QUANTUM_RESET;
      clock_now = '0;
      wait_total = '0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_QUANTUM)
        quantum_q = pwdata[QUANT_W-1:0];
      if (s_tvalid && s_tready) begin
        schedule_item(s_tuser[0], s_tdata[ID_W-1:0], s_tdata[ID_W +: BURST_W], res);
        pending_results.push_back(res);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rrts_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W = ((OUT_FIX_W + CNT_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 188;
  localparam logic [APB_ADDR_W-1:0] QUANTUM_ADDR = {REG_QUANTUM, 2'b00};

  logic                  clk;
  logic                  rst;
  // task_id[7:0], burst[23:8]
  logic [IN_DATA_W-1:0]  s_tdata;
  // action[0]
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  // running_valid[0], running_task[8:1], finished_valid[9], finished_task[17:10],
  // finished_wait[49:18], slice_expired[50], add_dropped[51], total_wait[99:52],
  // queue_count[104:100], zero fill above
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;
  logic                  steady;
  int                    idle_cycles;

  round_robin_time_slice_scheduler_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (.*);

  sched_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic action, input logic [ID_W-1:0] id,
                           input logic [BURST_W-1:0] need);
    s_tuser <= action;
    s_tdata <= {need, id};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!steady && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    logic [BURST_W-1:0] need;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 91)
      need = BURST_W'($urandom_range(1, 8));
    else if (pick < 99)
      need = BURST_W'($urandom_range(9, 32));
    else
      need = BURST_W'($urandom_range(1, 65535));
    send_item(($urandom_range(0, 99) < 15) ? ACT_ADD : ACT_TICK,
              ID_W'($urandom_range(0, 255)), need);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [QUANT_W-1:0] quantum;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ticks on an empty queue, adds to empty and running queue, finish, rotate
    send_item(ACT_TICK, 8'hFF, 16'hFFFF);
    send_item(ACT_TICK, 8'h00, 16'h0000);
    send_item(ACT_ADD, 8'h00, 16'd1);
    send_item(ACT_ADD, 8'hFF, 16'hFFFF);
    send_item(ACT_ADD, 8'hA5, 16'd3);
    repeat (6) send_item(ACT_TICK, 8'h00, 16'd0);
    // fill the queue, then overflow it
    repeat (14) send_item(ACT_ADD, ID_W'($urandom_range(0, 255)),
                          BURST_W'($urandom_range(1, 4)));
    send_item(ACT_ADD, 8'h5A, 16'd7);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == 0)
        quantum = 8'd1;
      else if (p == 1)
        quantum = 8'd255;
      else
        quantum = QUANT_W'($urandom_range(1, (p % 2) ? 255 : 8));
      write_reg(QUANTUM_ADDR, APB_DATA_W'(quantum));
      steady <= (p == 3);
      @(posedge clk);
      repeat (PHASE_ITEMS) send_random_item();
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
